// ===== design/amcd_pkg.sv =====
// amcd_pkg: shared types and constants for the actuator mask cooldown driver.
// No dependencies; imported by every module of the block.
package amcd_pkg;

  localparam int MASK_W = 20;   // width of the target mask fields
  localparam int NOW_W  = 32;   // millisecond time stamp width
  localparam int CD_W   = 16;   // cooldown register width

  localparam logic [CD_W-1:0] CD_RESET = 16'd500;

  localparam logic CMD_APPLY = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_POST = 3'b100
  } state_t;

  // request from the sequencer to the timer bank for one target slot
  typedef struct packed {
    logic active;
    logic pending;
  } tmr_req_t;

endpackage

// ===== design/amcd_timer_bank.sv =====
// amcd_timer_bank: flip time stamp per target plus the shared elapsed-time
// subtract and cooldown compare. Depends on amcd_pkg.
module amcd_timer_bank import amcd_pkg::*; #(
  parameter int NT    = 20,
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tmr_req_t         req,
  input  logic [IDX_W-1:0] idx,
  input  logic [NOW_W-1:0] now,
  input  logic [CD_W-1:0]  cooldown,
  output logic             flip
);

  logic [NOW_W-1:0] stamp_r [NT];
  logic [NOW_W-1:0] elapsed;

  // wraps modulo 2^32, as the free-running clock does
  assign elapsed = now - stamp_r[idx];
  assign flip    = req.active & req.pending & (elapsed >= NOW_W'(cooldown));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) begin
        stamp_r[i] <= '0;
      end
    end else if (flip) begin
      stamp_r[idx] <= now;
    end
  end

endmodule

// ===== design/actuator_mask_cooldown_driver.sv =====
// actuator_mask_cooldown_driver: top level, sequencer, mask state, config
// register and output register. Depends on amcd_pkg and amcd_timer_bank.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | input     | in_valid/in_ready  | cmd, target_mask, new_state, now
//  out_    | output    | out_valid/out_ready| drive_mask, flipped_mask, written
//  cfg_    | input     | cfg_we             | cooldown_ms
//
// A command beat goes from idle straight to the post step; an evaluate beat first
// walks every target in the evaluate state: the timer bank visits one target per cycle.
// in_ready is high only while idle; a finished result waits in the output
// register, and the next beat may be taken meanwhile. The final step of the
// next beat stalls until that held result has been taken.
// rst_n is synchronous: masks, flip times and sequencer clear, cooldown -> 500.
module actuator_mask_cooldown_driver import amcd_pkg::*; #(
  parameter int TARGET_COUNT = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [MASK_W-1:0] in_target_mask,
  input  logic              in_new_state,
  input  logic [NOW_W-1:0]  in_now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] out_drive_mask,
  output logic [MASK_W-1:0] out_flipped_mask,
  output logic              out_drive_written,
  input  logic              cfg_we,
  input  logic [CD_W-1:0]   cfg_wdata
);

  // targets that can be addressed through the mask fields
  localparam int NT    = (TARGET_COUNT < MASK_W) ? TARGET_COUNT : MASK_W;
  localparam int IDX_W = (NT > 1) ? $clog2(NT) : 1;
  localparam logic [MASK_W-1:0] EXIST_MASK = {MASK_W{1'b1}} >> (MASK_W - NT);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NT - 1);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [MASK_W-1:0] wanted_r, wanted_nxt;
  logic [MASK_W-1:0] driven_r, driven_nxt;
  logic [NT-1:0]     acc_r, acc_nxt;
  logic [NOW_W-1:0]  now_r, now_nxt;
  logic [CD_W-1:0]   cooldown_r;

  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_drive_r, out_drive_nxt;
  logic [MASK_W-1:0] out_flip_r, out_flip_nxt;
  logic              out_wr_r, out_wr_nxt;

  logic              in_beat;
  logic              out_free;
  logic [MASK_W-1:0] cmd_mask;
  logic [NT-1:0]     pend_v;
  logic [MASK_W-1:0] acc_ext;
  tmr_req_t          tmr_req;
  logic              flip;

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;
  assign cmd_mask = in_target_mask & EXIST_MASK;
  assign pend_v   = wanted_r[NT-1:0] ^ driven_r[NT-1:0];
  assign acc_ext  = MASK_W'(acc_r);

  assign tmr_req.active  = (state_r == ST_EVAL);
  assign tmr_req.pending = pend_v[idx_r];

  amcd_timer_bank #(
    .NT    (NT),
    .IDX_W (IDX_W)
  ) u_timers (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (tmr_req),
    .idx      (idx_r),
    .now      (now_r),
    .cooldown (cooldown_r),
    .flip     (flip)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    wanted_nxt    = wanted_r;
    driven_nxt    = driven_r;
    acc_nxt       = acc_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_drive_nxt = out_drive_r;
    out_flip_nxt  = out_flip_r;
    out_wr_nxt    = out_wr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          acc_nxt = '0;
          idx_nxt = '0;
          if (in_cmd == CMD_EVAL) begin
            now_nxt   = in_now_ms;
            state_nxt = ST_EVAL;
          end else begin
            wanted_nxt = in_new_state ? (wanted_r | cmd_mask) : (wanted_r & ~cmd_mask);
            state_nxt  = ST_POST;
          end
        end
      end
      ST_EVAL: begin
        acc_nxt[idx_r] = flip;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_POST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_POST: begin
        if (out_free) begin
          driven_nxt    = driven_r ^ acc_ext;
          out_valid_nxt = 1'b1;
          out_drive_nxt = driven_r ^ acc_ext;
          out_flip_nxt  = acc_ext;
          out_wr_nxt    = |acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      wanted_r    <= '0;
      driven_r    <= '0;
      cooldown_r  <= CD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      wanted_r    <= wanted_nxt;
      driven_r    <= driven_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cooldown_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    now_r       <= now_nxt;
    out_drive_r <= out_drive_nxt;
    out_flip_r  <= out_flip_nxt;
    out_wr_r    <= out_wr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_drive_mask    = out_drive_r;
  assign out_flipped_mask  = out_flip_r;
  assign out_drive_written = out_wr_r;

endmodule

// ===== design/amcd_checker.sv =====
// amcd_checker: port-level assertions for actuator_mask_cooldown_driver,
// bound to the top level below. Depends on amcd_pkg.
module amcd_checker import amcd_pkg::*; #(
  parameter int TARGET_COUNT = 20
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [MASK_W-1:0] out_drive_mask,
  input logic [MASK_W-1:0] out_flipped_mask,
  input logic              out_drive_written
);

  localparam int NT = (TARGET_COUNT < MASK_W) ? TARGET_COUNT : MASK_W;
  localparam logic [MASK_W-1:0] EXIST_MASK = {MASK_W{1'b1}} >> (MASK_W - NT);

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_mask)
      && $stable(out_flipped_mask) && $stable(out_drive_written))
    else $error("result beat changed while stalled");

  // written flag follows flipped bits
  a_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_written == (out_flipped_mask != '0)))
    else $error("drive_written disagrees with flipped_mask");

  // nonexistent targets never flip nor drive
  a_exist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_flipped_mask & ~EXIST_MASK) == '0)
      && ((out_drive_mask & ~EXIST_MASK) == '0))
    else $error("nonexistent target active");

  // an accepted beat keeps in_ready low in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken back to back");

endmodule

bind actuator_mask_cooldown_driver amcd_checker #(
  .TARGET_COUNT (TARGET_COUNT)
) u_amcd_checker (.*);

// ===== tb/tb_actuator_mask_cooldown_driver.sv =====
`timescale 1ns / 100ps
// tb_actuator_mask_cooldown_driver: self-checking bench for the actuator mask cooldown driver.
// Directed and random beats are checked against an in-bench model of the masks and flip times.
// Depends on amcd_pkg and actuator_mask_cooldown_driver.
module tb_actuator_mask_cooldown_driver;
  import amcd_pkg::*;

  localparam int TARGETS       = 20;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct {
    logic [MASK_W-1:0] drive;
    logic [MASK_W-1:0] flipped;
    logic              written;
  } drive_beat_t;

  logic              clk               = 1'b0;
  logic              rst_n             = 1'b0;
  logic              in_valid          = 1'b0;
  logic              in_ready;
  logic              in_cmd            = CMD_APPLY;
  logic [MASK_W-1:0] in_target_mask    = '0;
  logic              in_new_state      = 1'b0;
  logic [NOW_W-1:0]  in_now_ms         = '0;
  logic              out_valid;
  logic              out_ready         = 1'b0;
  logic [MASK_W-1:0] out_drive_mask;
  logic [MASK_W-1:0] out_flipped_mask;
  logic              out_drive_written;
  logic              cfg_we            = 1'b0;
  logic [CD_W-1:0]   cfg_wdata         = '0;

  // model of the block
  logic [MASK_W-1:0] want_bits;
  logic [MASK_W-1:0] face_bits;
  logic [NOW_W-1:0]  flip_stamp [TARGETS];
  logic [CD_W-1:0]   hold_ms;

  drive_beat_t       pending_beats [$];
  logic              idle_on;
  logic [NOW_W-1:0]  wall_ms;
  int                mismatches;
  int                cycles = 0;

  always #5 clk = ~clk;

  actuator_mask_cooldown_driver #(.TARGET_COUNT(TARGETS)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_target_mask    (in_target_mask),
    .in_new_state      (in_new_state),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_drive_mask    (out_drive_mask),
    .out_flipped_mask  (out_flipped_mask),
    .out_drive_written (out_drive_written),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  function automatic drive_beat_t advance_masks(input logic cmd, input logic [MASK_W-1:0] tmask,
                                                input logic st, input logic [NOW_W-1:0] now);
    drive_beat_t       r;
    logic [MASK_W-1:0] live;
    logic [MASK_W-1:0] ready;
    logic [NOW_W-1:0]  age;
    live  = MASK_W'((64'd1 << TARGETS) - 1);
    ready = '0;
    tmask = tmask & live;
    if (cmd == CMD_APPLY) begin
      if (st) want_bits = want_bits | tmask;
      else want_bits = want_bits & ~tmask;
    end else begin
      for (int i = 0; i < TARGETS; i++) begin
        age = now - flip_stamp[i];   // wraps at 32 bits
        if ((want_bits[i] ^ face_bits[i]) && age >= NOW_W'(hold_ms)) begin
          ready[i]      = 1'b1;
          flip_stamp[i] = now;
        end
      end
      face_bits = face_bits ^ ready;
    end
    r.drive   = face_bits;
    r.flipped = ready;
    r.written = |ready;
    return r;
  endfunction

  // valid stays high after acceptance; the next call either moves the payload on or drops it
  task automatic send_item(input logic cmd, input logic [MASK_W-1:0] tmask, input logic st,
                           input logic [NOW_W-1:0] now);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_target_mask <= tmask;
    in_new_state   <= st;
    in_now_ms      <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_beats.push_back(advance_masks(cmd, tmask, st, now));
  endtask

  task automatic command(input logic [MASK_W-1:0] tmask, input logic st);
    send_item(CMD_APPLY, tmask, st, $urandom);
  endtask

  task automatic eval_at(input logic [NOW_W-1:0] now);
    wall_ms = now;
    send_item(CMD_EVAL, MASK_W'($urandom), 1'($urandom_range(0, 1)), now);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hold(input logic [CD_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    hold_ms = v;
  endtask

  // reset cooldown, early-after-reset hold-off, set/clear and wraparound of the time stamp
  task automatic test_reset_defaults();
    idle_on = 1'b1;
    command('1, 1'b1);
    eval_at(32'd0);
    eval_at(32'd499);
    eval_at(32'd500);
    command(20'h00001, 1'b0);
    command(20'h80000, 1'b0);
    eval_at(32'd999);
    eval_at(32'd1000);
    command(20'h80001, 1'b1);
    eval_at(32'hFFFF_FFFF);
    command(20'h80001, 1'b0);
    eval_at(32'h0000_01F2);   // 499 ms across the wrap
    eval_at(32'h0000_01F3);
  endtask

  task automatic test_cooldown_extremes();
    idle_on = 1'b0;
    write_hold(16'd0);
    command(20'h0F0F0, 1'b1);
    eval_at(wall_ms);
    command(20'h0F0F0, 1'b0);
    eval_at(wall_ms);         // zero cooldown: flips back at the same time
    eval_at(wall_ms);
    write_hold(16'hFFFF);
    command(20'hA5A5A, 1'b1);
    eval_at(wall_ms + 32'd65534);
    eval_at(wall_ms + 32'd1);
    command(20'hFFFFF, 1'b0);
    eval_at(wall_ms + 32'd65535);
    write_hold(CD_RESET);
  endtask

  task automatic random_phase(input int beats);
    logic [MASK_W-1:0] m;
    logic [NOW_W-1:0]  stride;
    int                pick;
    for (int n = 0; n < beats; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 3))
          0: m = MASK_W'($urandom);
          1: m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
          2: m = '1;
          default: m = MASK_W'($urandom) & MASK_W'($urandom);
        endcase
        command(m, 1'($urandom_range(0, 1)));
      end else begin
        if (pick < 40) stride = $urandom;
        else if (pick < 52) stride = NOW_W'(hold_ms) + $urandom_range(0, 2) - 1;
        else stride = $urandom_range(0, 2 * int'(hold_ms) + 1);
        eval_at(wall_ms + stride);
      end
      if ($urandom_range(0, 149) == 0) settle();
    end
  endtask

  task automatic test_random_traffic();
    logic [CD_W-1:0] holds [6];
    holds[0] = CD_W'($urandom_range(1, 1000));
    holds[1] = 16'd0;
    holds[2] = 16'hFFFF;
    holds[3] = CD_W'($urandom);
    holds[4] = CD_W'($urandom_range(1, 20));
    holds[5] = CD_RESET;
    for (int p = 0; p < 6; p++) begin
      write_hold(holds[p]);
      idle_on = (p % 2 == 0);
      random_phase(105);
    end
  endtask

  // result side: random stall per beat while idle_on is set
  initial begin
    int stall;
    forever begin
      stall = idle_on ? $urandom_range(0, 15) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    drive_beat_t due;
    if (rst_n && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with none outstanding: drive_mask %h", out_drive_mask);
        mismatches++;
      end else begin
        due = pending_beats.pop_front();
        if (out_drive_mask !== due.drive) begin
          $error("drive_mask expected %h actual %h", due.drive, out_drive_mask);
          mismatches++;
        end
        if (out_flipped_mask !== due.flipped) begin
          $error("flipped_mask expected %h actual %h", due.flipped, out_flipped_mask);
          mismatches++;
        end
        if (out_drive_written !== due.written) begin
          $error("drive_written expected %b actual %b", due.written, out_drive_written);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    hold_ms    = CD_RESET;
    want_bits  = '0;
    face_bits  = '0;
    for (int i = 0; i < TARGETS; i++) flip_stamp[i] = '0;
    idle_on    = 1'b1;
    wall_ms    = '0;
    mismatches = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_cooldown_extremes();
    test_random_traffic();
    settle();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
